// ===== hdl/wht_pkg.sv =====
package wht_pkg;

   // vector geometry
   localparam int PTS      = 32;
   localparam int PTS_LOG2 = $clog2(PTS);
   localparam int ADDR_W   = PTS_LOG2;
   localparam int PAIR_W   = PTS_LOG2 - 1;
   localparam int STG_W    = $clog2(PTS_LOG2);

   // word widths
   localparam int IN_W   = 32;
   localparam int COEF_W = IN_W + PTS_LOG2;

   // sequencing limits
   localparam logic [PAIR_W-1:0] LAST_PAIR  = PAIR_W'(PTS / 2 - 1);
   localparam logic [STG_W-1:0]  LAST_STAGE = STG_W'(PTS_LOG2 - 1);
   localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(PTS - 1);

   // sequencer states
   typedef enum logic [4:0] {
      ST_LOAD = 5'b00001,
      ST_RD   = 5'b00010,
      ST_WP   = 5'b00100,
      ST_WQ   = 5'b01000,
      ST_EMIT = 5'b10000
   } state_type;

   // lower address of a butterfly: pair index with a zero bit inserted at the stage
   function automatic logic [ADDR_W-1:0] pair_lo(input logic [PAIR_W-1:0] pair,
                                                 input logic [STG_W-1:0]  stage);
      logic [ADDR_W-1:0] wide;
      logic [ADDR_W-1:0] mask;
      wide = ADDR_W'(pair);
      mask = (ADDR_W'(1) << stage) - ADDR_W'(1);
      return ((wide & ~mask) << 1) | (wide & mask);
   endfunction

   // partner address: the stride bit set
   function automatic logic [ADDR_W-1:0] pair_hi(input logic [PAIR_W-1:0] pair,
                                                 input logic [STG_W-1:0]  stage);
      return pair_lo(pair, stage) | (ADDR_W'(1) << stage);
   endfunction

endpackage

// ===== hdl/wht_ram.sv =====
// one write port, two registered read ports
module wht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_addr_a];
      rd_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// ===== hdl/walsh_hadamard_32_point.sv =====
// 32-point fast Walsh-Hadamard transform, unnormalized, natural order.
// Samples enter one word per cycle while busy is low; the 32nd sample starts the
// transform and busy rises. Five butterfly stages of 16 butterflies each run on a
// single shared add/subtract unit over a 32-entry store with one write port, so
// each butterfly writes its sum and then its difference. The 32 coefficients are
// then read out in index order, one per cycle, pass through the store's read
// register and the output register, and appear on rsp_coefficient with
// rsp_strobe high for exactly one cycle each and rsp_last on index 31. The
// receiver cannot stall and every coefficient must be taken when strobed. busy
// stays high until the last coefficient has been read from the store. With
// csr_inverse_mode set, each coefficient is arithmetic-shifted right by five.
module walsh_hadamard_32_point
   import wht_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [IN_W-1:0]   req_sample,
   output logic              rsp_strobe,
   output logic [COEF_W-1:0] rsp_coefficient,
   output logic              rsp_last,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_inverse_mode
);

   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] fill_ff, fill_in;
   logic [PAIR_W-1:0] pair_ff, pair_in;
   logic [STG_W-1:0]  stg_ff, stg_in;
   logic [ADDR_W-1:0] emit_ff, emit_in;
   logic              inv_ff, inv_in;
   logic              rd_pend_ff;
   logic              rd_last_ff;
   logic              strobe_ff;
   logic              last_ff;
   logic [COEF_W-1:0] coef_ff;

   logic              accept;
   logic              bf_done;
   logic [PAIR_W-1:0] pair_nxt;
   logic [STG_W-1:0]  stg_nxt;
   logic              bf_sub;
   logic [COEF_W-1:0] bf_operand;
   logic [COEF_W-1:0] bf_result;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [COEF_W-1:0] wr_data;
   logic [ADDR_W-1:0] rd_addr_a;
   logic [ADDR_W-1:0] rd_addr_b;
   logic [COEF_W-1:0] rd_data_a;
   logic [COEF_W-1:0] rd_data_b;
   logic [COEF_W-1:0] coef_val;

   assign busy      = (state_ff != ST_LOAD);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;

   // butterfly counter advance
   assign bf_done = (pair_ff == LAST_PAIR) && (stg_ff == LAST_STAGE);
   always_comb begin
      if (pair_ff == LAST_PAIR) begin
         pair_nxt = '0;
         stg_nxt  = stg_ff + STG_W'(1);
      end else begin
         pair_nxt = pair_ff + PAIR_W'(1);
         stg_nxt  = stg_ff;
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      fill_in  = fill_ff;
      pair_in  = pair_ff;
      stg_in   = stg_ff;
      emit_in  = emit_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               fill_in = fill_ff + ADDR_W'(1);
               if (fill_ff == LAST_ADDR) begin
                  state_in = ST_RD;
                  pair_in  = '0;
                  stg_in   = '0;
               end
            end
         end
         ST_RD: begin
            state_in = ST_WP;
         end
         ST_WP: begin
            state_in = ST_WQ;
         end
         ST_WQ: begin
            if (bf_done) begin
               state_in = ST_EMIT;
               emit_in  = '0;
            end else begin
               state_in = ST_WP;
               pair_in  = pair_nxt;
               stg_in   = stg_nxt;
            end
         end
         ST_EMIT: begin
            emit_in = emit_ff + ADDR_W'(1);
            if (emit_ff == LAST_ADDR) begin
               state_in = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // shared butterfly unit: a + b on the sum cycle, a - b on the difference cycle
   assign bf_sub     = (state_ff == ST_WQ);
   assign bf_operand = bf_sub ? ~rd_data_b : rd_data_b;
   assign bf_result  = rd_data_a + bf_operand + COEF_W'(bf_sub);

   // store write port: samples, then butterfly sum and difference
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = fill_ff;
      wr_data = {{(COEF_W - IN_W){req_sample[IN_W-1]}}, req_sample};
      unique case (state_ff)
         ST_LOAD: begin
            wr_en = accept;
         end
         ST_WP: begin
            wr_en   = 1'b1;
            wr_addr = pair_lo(pair_ff, stg_ff);
            wr_data = bf_result;
         end
         ST_WQ: begin
            wr_en   = 1'b1;
            wr_addr = pair_hi(pair_ff, stg_ff);
            wr_data = bf_result;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   // read addresses: next butterfly is fetched while the difference is written;
   // during the sum cycle the same pair is read again, so the old operands stay
   // on the read ports for the difference
   always_comb begin
      unique case (state_ff)
         ST_WQ: begin
            rd_addr_a = pair_lo(pair_nxt, stg_nxt);
            rd_addr_b = pair_hi(pair_nxt, stg_nxt);
         end
         ST_EMIT: begin
            rd_addr_a = emit_ff;
            rd_addr_b = emit_ff;
         end
         default: begin
            rd_addr_a = pair_lo(pair_ff, stg_ff);
            rd_addr_b = pair_hi(pair_ff, stg_ff);
         end
      endcase
   end

   wht_ram #(
      .WIDTH (COEF_W),
      .DEPTH (PTS)
   ) u_store (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_data_a (rd_data_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_b (rd_data_b)
   );

   // mode register
   assign inv_in = (csr_valid && csr_ready) ? csr_inverse_mode : inv_ff;

   // inverse scaling on the read word
   assign coef_val = inv_ff ? COEF_W'($signed(rd_data_a) >>> PTS_LOG2) : rd_data_a;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_LOAD;
         fill_ff    <= '0;
         pair_ff    <= '0;
         stg_ff     <= '0;
         emit_ff    <= '0;
         inv_ff     <= 1'b0;
         rd_pend_ff <= 1'b0;
         strobe_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         fill_ff    <= fill_in;
         pair_ff    <= pair_in;
         stg_ff     <= stg_in;
         emit_ff    <= emit_in;
         inv_ff     <= inv_in;
         rd_pend_ff <= (state_ff == ST_EMIT);
         strobe_ff  <= rd_pend_ff;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rd_last_ff <= (emit_ff == LAST_ADDR);
      last_ff    <= rd_last_ff;
      coef_ff    <= coef_val;
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_coefficient = coef_ff;
   assign rsp_last        = strobe_ff && last_ff;

endmodule

// ===== test/wht_scoreboard_pkg.sv =====
package wht_scoreboard_pkg;
   import wht_pkg::*;

   // one expected output word
   typedef struct packed {
      logic [COEF_W-1:0] coef;
      logic              last;
   } coef_word_type;

   class wht_scoreboard;
      logic signed [COEF_W-1:0] vec[PTS];
      int                       fill;
      bit                       inverse;
      coef_word_type            coef_queue[$];
      int                       errors;

      function new();
         fill    = 0;
         inverse = 0;
         errors  = 0;
      endfunction

      function void set_mode(bit mode);
         inverse = mode;
      endfunction

      function int pending();
         return coef_queue.size();
      endfunction

      // collect one sample; the one that fills the vector runs the transform
      function void note_sample(logic [IN_W-1:0] sample);
         int                       stride;
         int                       base;
         int                       j;
         int                       k;
         logic signed [COEF_W-1:0] a;
         logic signed [COEF_W-1:0] b;
         logic signed [COEF_W-1:0] v;
         coef_word_type            w;
         vec[fill] = {{(COEF_W-IN_W){sample[IN_W-1]}}, sample};
         fill++;
         if (fill < PTS) return;
         fill = 0;
         // butterfly stages, stride 1 up to PTS/2; 37 bits keep sums exact
         for (stride = 1; stride < PTS; stride = stride * 2) begin
            for (base = 0; base < PTS; base = base + 2 * stride) begin
               for (j = 0; j < stride; j++) begin
                  a = vec[base + j];
                  b = vec[base + j + stride];
                  vec[base + j]          = a + b;
                  vec[base + j + stride] = a - b;
               end
            end
         end
         // natural order out; inverse is a floor divide by PTS
         for (k = 0; k < PTS; k++) begin
            v = vec[k];
            if (inverse) v = v >>> PTS_LOG2;
            w.coef = v;
            w.last = (k == PTS - 1);
            coef_queue.push_back(w);
         end
      endfunction

      task report(string msg);
         $display("ERROR: %s", msg);
         errors++;
      endtask

      // compare one strobed word with the oldest expectation
      task check_result(logic [COEF_W-1:0] coef, logic last);
         coef_word_type w;
         if (coef_queue.size() == 0) begin
            report($sformatf("unexpected coefficient %0d", $signed(coef)));
            return;
         end
         w = coef_queue.pop_front();
         if (coef !== w.coef)
            report($sformatf("coefficient %0d, want %0d", $signed(coef), $signed(w.coef)));
         if (last !== w.last)
            report($sformatf("last %b, want %b", last, w.last));
      endtask
   endclass

endpackage

// ===== test/tb.sv =====
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import wht_pkg::*;
   import wht_scoreboard_pkg::*;

   localparam int QUIET_LIMIT = 3000;
   localparam logic [IN_W-1:0] SAMPLE_MIN = {1'b1, {(IN_W-1){1'b0}}};
   localparam logic [IN_W-1:0] SAMPLE_MAX = ~SAMPLE_MIN;
   localparam int PHASES = 7;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic [IN_W-1:0]   req_sample = '0;
   logic              rsp_strobe;
   logic [COEF_W-1:0] rsp_coefficient;
   logic              rsp_last;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic              csr_inverse_mode = 1'b0;

   wht_scoreboard sb = new();
   int            idle_pct = 0;
   int            quiet_cycles = 0;

   int phase_len[PHASES]  = '{40, 45, 40, 45, 50, 30, 28};
   bit phase_mode[PHASES] = '{1, 0, 1, 0, 1, 0, 1};
   int phase_idle[PHASES] = '{0, 57, 0, 19, 57, 0, 19};

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   walsh_hadamard_32_point dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_sample       (req_sample),
      .rsp_strobe       (rsp_strobe),
      .rsp_coefficient  (rsp_coefficient),
      .rsp_last         (rsp_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_inverse_mode (csr_inverse_mode)
   );

   // monitor: every accepted word goes to the scoreboard; watchdog on silence
   always @(posedge clock) begin : monitor
      bit moved;
      moved = 1'b0;
      if (!reset) begin
         if (rsp_strobe) begin
            sb.check_result(rsp_coefficient, rsp_last);
            moved = 1'b1;
         end
         if (start && !busy) begin
            sb.note_sample(req_sample);
            moved = 1'b1;
         end
         if (csr_valid && csr_ready) begin
            sb.set_mode(csr_inverse_mode);
            moved = 1'b1;
         end
         quiet_cycles = moved ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   // called at a falling edge, returns at a falling edge
   task automatic send_sample(logic [IN_W-1:0] value);
      while ($urandom_range(99) < idle_pct) begin
         start      <= 1'b0;
         req_sample <= $urandom();
         @(negedge clock);
      end
      start      <= 1'b1;
      req_sample <= value;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   task automatic drain();
      while (sb.pending() != 0) @(negedge clock);
   endtask

   // mode change only once the block has gone quiet
   task automatic write_mode(bit mode);
      drain();
      repeat (8) @(negedge clock);
      csr_valid        <= 1'b1;
      csr_inverse_mode <= mode;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // mix of extremes, small signed values and full-range noise
   function automatic logic [IN_W-1:0] pick_sample();
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 1) ? SAMPLE_MIN : SAMPLE_MAX;
         1: return IN_W'(int'($urandom_range(0, 15)) - 8);
         default: return $urandom();
      endcase
   endfunction

   initial begin
      int p;
      int n;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: all-minimum vector drives coefficient 0 to the bottom of its range
      write_mode(1'b0);
      for (n = 0; n < PTS; n++) send_sample(SAMPLE_MIN);
      start <= 1'b0;

      // random phases; lengths leave vectors partly filled across mode changes
      for (p = 0; p < PHASES; p++) begin
         idle_pct = phase_idle[p];
         write_mode(phase_mode[p]);
         for (n = 0; n < phase_len[p]; n++) send_sample(pick_sample());
         start <= 1'b0;
      end

      drain();
      repeat (20) @(negedge clock);
      if (sb.pending() != 0)
         sb.report($sformatf("%0d coefficients never arrived", sb.pending()));
      if (sb.errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
